// ===== hdl/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// Slice statistics package
// Shared widths, step counts and the record types that pass between the
// accumulator, the controller and the post-processing datapath.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int SSS_MAX_SLICE_LEN = 1024;

    localparam int SSS_SAMPLE_W = 8;
    localparam int SSS_SUM_W    = 18;
    localparam int SSS_ENERGY_W = 25;
    localparam int SSS_COUNT_W  = 11;
    localparam int SSS_TRANS_W  = 10;
    localparam int SSS_MEAN_W   = 16;
    localparam int SSS_STD_W    = 16;

    // Quotient magnitude of the mean and the width of the shared divider.
    localparam int SSS_QMAG_W   = SSS_SUM_W + 8;
    localparam int SSS_DIV_W    = SSS_ENERGY_W + 16;
    localparam int SSS_SQ_W     = 2 * SSS_QMAG_W;

    // Square root: radicand padded to an even width, one root bit per step.
    localparam int SSS_RAD_W    = SSS_DIV_W + 1;
    localparam int SSS_ROOT_W   = SSS_RAD_W / 2;
    localparam int SSS_SREM_W   = SSS_ROOT_W + 2;

    localparam int SSS_DIV_STEPS  = SSS_DIV_W;
    localparam int SSS_ROOT_STEPS = SSS_ROOT_W;
    localparam int SSS_STEP_W     = $clog2(SSS_DIV_STEPS);

    typedef struct packed {
        logic [SSS_SUM_W-1:0]    sum;
        logic [SSS_ENERGY_W-1:0] energy;
        logic [SSS_COUNT_W-1:0]  count;
        logic [SSS_COUNT_W-1:0]  nonzero;
        logic [SSS_TRANS_W-1:0]  trans;
    } t_slice;

    typedef struct packed {
        logic load;
        logic div_step;
        logic ms_start;
        logic square;
        logic diff;
        logic sqrt_step;
    } t_post_cmd;

    typedef struct packed {
        logic [SSS_SUM_W-1:0]    sum;
        logic [SSS_ENERGY_W-1:0] energy;
        logic [SSS_COUNT_W-1:0]  count;
        logic [SSS_COUNT_W-1:0]  nonzero;
        logic [SSS_TRANS_W-1:0]  trans;
        logic [SSS_MEAN_W-1:0]   mean;
        logic [SSS_STD_W-1:0]    stddev;
    } t_result;

endpackage

// ===== hdl/sss_accum.sv =====
// ----------------------------------------------------------------------------
// Slice accumulator
// Adds one sample per transfer to the running sums and counts and, when a
// slice closes, parks the finished totals in a snapshot register.
// ----------------------------------------------------------------------------
module sss_accum #(
    parameter int MAX_SLICE_LEN = sss_pkg::SSS_MAX_SLICE_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic signed [sss_pkg::SSS_SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    input  logic                                i_snap_take,
    output logic                                o_snap_valid,
    output sss_pkg::t_slice                     o_snap
);
    import sss_pkg::*;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    logic [SSS_SUM_W-1:0]    r_sum, n_sum;
    logic [SSS_ENERGY_W-1:0] r_energy, n_energy;
    logic [SSS_COUNT_W-1:0]  r_count, n_count;
    logic [SSS_COUNT_W-1:0]  r_nonzero, n_nz_cnt;
    logic [SSS_COUNT_W-1:0]  r_trans, n_trans;
    logic [1:0]              r_prev, n_prev;
    logic                    r_snap_valid;
    t_slice                  r_snap;
    logic [SSS_SAMPLE_W-1:0] w_mag;
    logic [2*SSS_SAMPLE_W-1:0] w_sqr;
    logic                    w_close;

    always_comb begin
        w_mag = i_sample[SSS_SAMPLE_W-1] ? (SSS_SAMPLE_W'(0) - i_sample) : i_sample;
        w_sqr = w_mag * w_mag;
        if (i_sample[SSS_SAMPLE_W-1]) begin
            n_prev = SIGN_NEG;
        end else if (i_sample != '0) begin
            n_prev = SIGN_POS;
        end else begin
            n_prev = SIGN_NONE;
        end
        n_sum     = r_sum + {{(SSS_SUM_W-SSS_SAMPLE_W){i_sample[SSS_SAMPLE_W-1]}}, i_sample};
        n_energy  = r_energy + {{(SSS_ENERGY_W-2*SSS_SAMPLE_W){1'b0}}, w_sqr};
        n_count   = r_count + 1'b1;
        n_nz_cnt  = (n_prev != SIGN_NONE) ? r_nonzero + 1'b1 : r_nonzero;
        n_trans   = (n_prev != SIGN_NONE && r_prev != SIGN_NONE && n_prev != r_prev)
                    ? r_trans + 1'b1 : r_trans;
        w_close   = i_last || (32'(n_count) >= 32'(MAX_SLICE_LEN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_energy     <= '0;
            r_count      <= '0;
            r_nonzero    <= '0;
            r_trans      <= '0;
            r_prev       <= SIGN_NONE;
            r_snap_valid <= 1'b0;
        end else begin
            if (i_snap_take) begin
                r_snap_valid <= 1'b0;
            end
            if (i_take) begin
                if (w_close) begin
                    r_sum        <= '0;
                    r_energy     <= '0;
                    r_count      <= '0;
                    r_nonzero    <= '0;
                    r_trans      <= '0;
                    r_prev       <= SIGN_NONE;
                    r_snap_valid <= 1'b1;
                end else begin
                    r_sum     <= n_sum;
                    r_energy  <= n_energy;
                    r_count   <= n_count;
                    r_nonzero <= n_nz_cnt;
                    r_trans   <= n_trans;
                    r_prev    <= n_prev;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && w_close) begin
            r_snap.sum     <= n_sum;
            r_snap.energy  <= n_energy;
            r_snap.count   <= n_count;
            r_snap.nonzero <= n_nz_cnt;
            r_snap.trans   <= n_trans[SSS_TRANS_W-1:0];
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    a_no_take_while_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_take && r_snap_valid && !i_snap_take))
        else $error("Sample taken while a closed slice is still parked.");

    a_clear_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && w_close) |=> (r_count == '0 && r_prev == SIGN_NONE && r_snap_valid))
        else $error("Accumulators not cleared after a slice closed.");

endmodule

// ===== hdl/sss_post.sv =====
// ----------------------------------------------------------------------------
// Slice post-processing datapath
// Holds a closed slice and derives its mean and standard deviation with a
// shared restoring divider, one squaring multiplier and a digit square root.
// ----------------------------------------------------------------------------
module sss_post (
    input  logic               i_clk,
    input  sss_pkg::t_post_cmd i_cmd,
    input  sss_pkg::t_slice    i_snap,
    output sss_pkg::t_result   o_result
);
    import sss_pkg::*;

    t_slice                  r_slice;
    logic [SSS_COUNT_W-1:0]  r_len;
    logic                    r_neg;
    logic [SSS_DIV_W-1:0]    r_dq;
    logic [SSS_COUNT_W-1:0]  r_drem;
    logic [SSS_QMAG_W-1:0]   r_qmag;
    logic [SSS_SQ_W-1:0]     r_sq;
    logic [SSS_RAD_W-1:0]    r_sx;
    logic [SSS_SREM_W-1:0]   r_srem;
    logic [SSS_ROOT_W-1:0]   r_root;

    logic [SSS_SUM_W-1:0]    w_abs;
    logic [SSS_COUNT_W:0]    w_rs;
    logic [SSS_COUNT_W:0]    w_dsub;
    logic                    w_dge;
    logic [SSS_SQ_W-1:0]     w_ms;
    logic [SSS_SREM_W+1:0]   w_cur;
    logic [SSS_SREM_W+1:0]   w_trial;
    logic                    w_sge;

    always_comb begin
        w_abs   = i_snap.sum[SSS_SUM_W-1] ? (SSS_SUM_W'(0) - i_snap.sum) : i_snap.sum;
        w_rs    = {r_drem, r_dq[SSS_DIV_W-1]};
        w_dsub  = w_rs - {1'b0, r_len};
        w_dge   = w_rs >= {1'b0, r_len};
        w_ms    = {{(SSS_SQ_W-SSS_DIV_W){1'b0}}, r_dq};
        w_cur   = {r_srem, r_sx[SSS_RAD_W-1 -: 2]};
        w_trial = {{(SSS_SREM_W-SSS_ROOT_W){1'b0}}, r_root, 2'b01};
        w_sge   = w_cur >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slice <= i_snap;
            r_len   <= (i_snap.count == '0) ? SSS_COUNT_W'(1) : i_snap.count;
            r_neg   <= i_snap.sum[SSS_SUM_W-1];
            r_dq    <= {{(SSS_DIV_W-SSS_QMAG_W){1'b0}}, w_abs, 8'b0};
            r_drem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq   <= {r_dq[SSS_DIV_W-2:0], w_dge};
            r_drem <= w_dge ? w_dsub[SSS_COUNT_W-1:0] : w_rs[SSS_COUNT_W-1:0];
        end
        if (i_cmd.ms_start) begin
            r_qmag <= r_dq[SSS_QMAG_W-1:0];
            r_dq   <= {r_slice.energy, 16'b0};
            r_drem <= '0;
        end
        if (i_cmd.square) begin
            r_sq <= r_qmag * r_qmag;
        end
        if (i_cmd.diff) begin
            r_sx   <= (w_ms > r_sq) ? {1'b0, r_dq - r_sq[SSS_DIV_W-1:0]} : '0;
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_srem <= w_sge ? SSS_SREM_W'(w_cur - w_trial) : SSS_SREM_W'(w_cur);
            r_root <= {r_root[SSS_ROOT_W-2:0], w_sge};
            r_sx   <= {r_sx[SSS_RAD_W-3:0], 2'b00};
        end
    end

    always_comb begin
        o_result.sum     = r_slice.sum;
        o_result.energy  = r_slice.energy;
        o_result.count   = r_slice.count;
        o_result.nonzero = r_slice.nonzero;
        o_result.trans   = r_slice.trans;
        o_result.mean    = r_neg ? (SSS_MEAN_W'(0) - r_qmag[SSS_MEAN_W-1:0])
                                 : r_qmag[SSS_MEAN_W-1:0];
        o_result.stddev  = r_root[SSS_STD_W-1:0];
    end

endmodule

// ===== hdl/sss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slice post-processing controller
// Sequences the load, the two divisions, the squaring, the subtraction and
// the square root, then holds the result until its transfer.
// ----------------------------------------------------------------------------
module sss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_valid,
    input  logic               i_result_ready,
    output logic               o_snap_take,
    output logic               o_result_valid,
    output sss_pkg::t_post_cmd o_cmd
);
    import sss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_MS_LOAD,
        ST_DIV_MS,
        ST_SQUARE,
        ST_DIFF,
        ST_SQRT,
        ST_DONE
    } t_state;

    localparam logic [SSS_STEP_W-1:0] DIV_LAST  = SSS_STEP_W'(SSS_DIV_STEPS - 1);
    localparam logic [SSS_STEP_W-1:0] ROOT_LAST = SSS_STEP_W'(SSS_ROOT_STEPS - 1);

    t_state                r_state;
    logic [SSS_STEP_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_snap_valid) begin
                        r_state <= ST_DIV_MEAN;
                    end
                end
                ST_DIV_MEAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_MS_LOAD;
                    end
                end
                ST_MS_LOAD: begin
                    r_state <= ST_DIV_MS;
                end
                ST_DIV_MS: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ROOT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_result_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_cnt   <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == ST_IDLE) && i_snap_valid;
        o_cmd.div_step  = (r_state == ST_DIV_MEAN) || (r_state == ST_DIV_MS);
        o_cmd.ms_start  = (r_state == ST_MS_LOAD);
        o_cmd.square    = (r_state == ST_SQUARE);
        o_cmd.diff      = (r_state == ST_DIFF);
        o_cmd.sqrt_step = (r_state == ST_SQRT);
        o_snap_take     = o_cmd.load;
        o_result_valid  = (r_state == ST_DONE);
    end

    a_done_after_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && $past(r_state) != ST_DONE) |-> $past(r_state) == ST_SQRT)
        else $error("Result presented without a completed square root.");

    a_mean_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_MEAN && r_cnt == DIV_LAST) |=> r_state == ST_MS_LOAD)
        else $error("Mean division did not finish after its full step count.");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> r_cnt <= ROOT_LAST)
        else $error("Square root step counter overran.");

endmodule

// ===== hdl/slice_stream_statistics_core.sv =====
// ----------------------------------------------------------------------------
// Slice stream statistics core
// Per-slice sum, energy, counts, sign transitions, mean and standard
// deviation over a stream of signed 8-bit samples.
// ----------------------------------------------------------------------------
// Sequence: a slice's closing sample is registered into the snapshot; the
// controller then loads it and runs the mean division, the mean-square load,
// the mean-square division, the squaring, the subtraction and the square root.
// Throughput: one sample per cycle while no closed slice is parked; a slice
// closing while post-processing is busy stays parked and stalls the input.
// Reset: synchronous, active low; clears all accumulators and the sequencer.
module slice_stream_statistics_core #(
    parameter int MAX_SLICE_LEN = sss_pkg::SSS_MAX_SLICE_LEN
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [sss_pkg::SSS_SAMPLE_W-1:0]  i_sample,
    input  logic                                     i_last,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [sss_pkg::SSS_SUM_W-1:0]     o_slice_sum,
    output logic [sss_pkg::SSS_ENERGY_W-1:0]         o_slice_energy,
    output logic [sss_pkg::SSS_COUNT_W-1:0]          o_element_count,
    output logic [sss_pkg::SSS_COUNT_W-1:0]          o_nonzero_count,
    output logic [sss_pkg::SSS_TRANS_W-1:0]          o_transition_count,
    output logic signed [sss_pkg::SSS_MEAN_W-1:0]    o_mean_q8,
    output logic [sss_pkg::SSS_STD_W-1:0]            o_stddev_q8
);
    import sss_pkg::*;

    logic      w_take;
    logic      w_snap_valid;
    logic      w_snap_take;
    t_slice    w_snap;
    t_post_cmd w_cmd;
    t_result   w_result;

    assign o_ready = !w_snap_valid;
    assign w_take  = i_valid && o_ready;

    sss_accum #(
        .MAX_SLICE_LEN(MAX_SLICE_LEN)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .i_snap_take  (w_snap_take),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap)
    );

    sss_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_snap_valid   (w_snap_valid),
        .i_result_ready (i_ready),
        .o_snap_take    (w_snap_take),
        .o_result_valid (o_valid),
        .o_cmd          (w_cmd)
    );

    sss_post u_post (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_snap   (w_snap),
        .o_result (w_result)
    );

    assign o_slice_sum        = w_result.sum;
    assign o_slice_energy     = w_result.energy;
    assign o_element_count    = w_result.count;
    assign o_nonzero_count    = w_result.nonzero;
    assign o_transition_count = w_result.trans;
    assign o_mean_q8          = w_result.mean;
    assign o_stddev_q8        = w_result.stddev;

endmodule

// ===== bench/slice_stream_statistics_core_tb.sv =====
// ----------------------------------------------------------------------------
// Slice stream statistics core testbench
// Streams signed samples in slices into the core under random gaps and
// backpressure. Each slice's sum, energy, counts, mean and standard deviation
// are predicted independently, and every returned result is compared field by
// field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module slice_stream_statistics_core_tb;

    import sss_pkg::*;

    typedef enum logic [1:0] {
        POL_NONE,
        POL_POS,
        POL_NEG
    } t_polarity;

    typedef enum int {
        STYLE_FULL,
        STYLE_QUIET,
        STYLE_SWING,
        STYLE_FLOOR,
        STYLE_CEIL
    } t_slice_style;

    typedef struct {
        logic signed [SSS_SAMPLE_W-1:0] sample;
        logic                           last;
        bit                             drain;
    } t_sample_item;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic signed [SSS_SAMPLE_W-1:0]    i_sample = '0;
    logic                              i_last = 1'b0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [SSS_SUM_W-1:0]       o_slice_sum;
    logic [SSS_ENERGY_W-1:0]           o_slice_energy;
    logic [SSS_COUNT_W-1:0]            o_element_count;
    logic [SSS_COUNT_W-1:0]            o_nonzero_count;
    logic [SSS_TRANS_W-1:0]            o_transition_count;
    logic signed [SSS_MEAN_W-1:0]      o_mean_q8;
    logic [SSS_STD_W-1:0]              o_stddev_q8;

    t_sample_item   sample_backlog[$];
    t_result        pending_results[$];
    t_result        oldest;

    logic signed [SSS_SUM_W-1:0]  running_sum = '0;
    logic [SSS_ENERGY_W-1:0]      running_energy = '0;
    logic [SSS_COUNT_W-1:0]       sample_count = '0;
    logic [SSS_COUNT_W-1:0]       nonzero_seen = '0;
    logic [SSS_TRANS_W:0]         sign_flips = '0;
    t_polarity                    prev_polarity = POL_NONE;

    int errors = 0;
    int samples_planned = 0;
    int samples_taken = 0;
    int slices_closed = 0;
    int limit_closes = 0;
    int results_checked = 0;
    int drain_pauses = 0;
    int tx_idle = 0;
    int tx_calm = 0;
    int rx_stall = 0;
    int rx_calm = 0;

    slice_stream_statistics_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample           (i_sample),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_slice_sum        (o_slice_sum),
        .o_slice_energy     (o_slice_energy),
        .o_element_count    (o_element_count),
        .o_nonzero_count    (o_nonzero_count),
        .o_transition_count (o_transition_count),
        .o_mean_q8          (o_mean_q8),
        .o_stddev_q8        (o_stddev_q8)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 22; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic void absorb_sample(input logic signed [SSS_SAMPLE_W-1:0] s,
                                          input logic last);
        int                v;
        t_polarity         pol;
        bit                at_limit;
        longint            sum_v;
        longint unsigned   qmag;
        longint unsigned   energy_ms;
        longint unsigned   spread;
        t_result           r;
        v = s;
        pol = (v > 0) ? POL_POS : ((v < 0) ? POL_NEG : POL_NONE);
        running_sum = running_sum + SSS_SUM_W'(v);
        running_energy = running_energy + SSS_ENERGY_W'(v * v);
        sample_count = sample_count + 1'b1;
        if (pol != POL_NONE) begin
            nonzero_seen = nonzero_seen + 1'b1;
        end
        if (pol != POL_NONE && prev_polarity != POL_NONE && pol != prev_polarity) begin
            sign_flips = sign_flips + 1'b1;
        end
        prev_polarity = pol;
        at_limit = (sample_count >= SSS_MAX_SLICE_LEN);
        if (last || at_limit) begin
            if (!last) begin
                limit_closes++;
            end
            sum_v = running_sum;
            qmag = (sum_v < 0) ? -sum_v : sum_v;
            qmag = (qmag << 8) / sample_count;
            energy_ms = running_energy;
            energy_ms = (energy_ms << 16) / sample_count;
            spread = (energy_ms > qmag * qmag) ? energy_ms - qmag * qmag : 0;
            r.sum = running_sum;
            r.energy = running_energy;
            r.count = sample_count;
            r.nonzero = nonzero_seen;
            r.trans = sign_flips[SSS_TRANS_W-1:0];
            r.mean = (sum_v < 0) ? SSS_MEAN_W'(-qmag) : SSS_MEAN_W'(qmag);
            r.stddev = SSS_STD_W'(floor_root(spread));
            pending_results.push_back(r);
            slices_closed++;
            running_sum = '0;
            running_energy = '0;
            sample_count = '0;
            nonzero_seen = '0;
            sign_flips = '0;
            prev_polarity = POL_NONE;
        end
    endfunction

    function automatic int draw_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(30, 120);
        end
        if (r < 60) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endfunction

    function automatic void queue_sample(input int v, input bit last, input bit drain);
        t_sample_item item;
        item.sample = SSS_SAMPLE_W'(v);
        item.last = last;
        item.drain = drain;
        sample_backlog.push_back(item);
    endfunction

    function automatic void add_slice(input int len, input t_slice_style style,
                                      input bit drain);
        int v;
        for (int k = 0; k < len; k++) begin
            case (style)
                STYLE_QUIET: v = int'($urandom_range(0, 6)) - 3;
                STYLE_SWING: v = (k % 2) ? -int'($urandom_range(1, 128))
                                         : int'($urandom_range(1, 127));
                STYLE_FLOOR: v = -128;
                STYLE_CEIL:  v = 127;
                default:     v = int'($urandom_range(0, 255)) - 128;
            endcase
            queue_sample(v, k == len - 1, drain && k == 0);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                absorb_sample(i_sample, i_last);
                samples_taken++;
            end
            if (!i_valid || o_ready) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    i_valid <= 1'b0;
                end else if (sample_backlog.size() > 0 &&
                             (!sample_backlog[0].drain || pending_results.size() == 0)) begin
                    if (sample_backlog[0].drain) begin
                        drain_pauses++;
                    end
                    i_valid <= 1'b1;
                    i_sample <= sample_backlog[0].sample;
                    i_last <= sample_backlog[0].last;
                    void'(sample_backlog.pop_front());
                    tx_idle = draw_pause(tx_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $error("result transfer with no slice outstanding");
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("slice_sum", $signed(oldest.sum), o_slice_sum);
                    check_field("slice_energy", oldest.energy, o_slice_energy);
                    check_field("element_count", oldest.count, o_element_count);
                    check_field("nonzero_count", oldest.nonzero, o_nonzero_count);
                    check_field("transition_count", oldest.trans, o_transition_count);
                    check_field("mean_q8", $signed(oldest.mean), o_mean_q8);
                    check_field("stddev_q8", oldest.stddev, o_stddev_q8);
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                rx_stall = draw_pause(rx_calm);
            end
        end
    end

    initial begin
        int random_items;
        int len;
        int pick;
        t_slice_style style;

        // Single-sample slices at the extremes and at zero.
        queue_sample(-128, 1'b1, 1'b0);
        queue_sample(127, 1'b1, 1'b0);
        queue_sample(0, 1'b1, 1'b0);
        // Transitions are counted only between adjacent non-zero samples.
        queue_sample(1, 1'b0, 1'b0);
        queue_sample(-1, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b0);
        queue_sample(-1, 1'b0, 1'b0);
        queue_sample(5, 1'b0, 1'b0);
        queue_sample(-128, 1'b0, 1'b0);
        queue_sample(127, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b0);
        queue_sample(3, 1'b1, 1'b0);
        // A negative mean that must truncate toward zero, sent once the core
        // has drained.
        queue_sample(-1, 1'b0, 1'b1);
        queue_sample(-1, 1'b0, 1'b0);
        queue_sample(-2, 1'b1, 1'b0);
        // A sign change across a slice boundary is not a transition.
        queue_sample(100, 1'b1, 1'b0);
        queue_sample(-100, 1'b0, 1'b0);
        queue_sample(50, 1'b1, 1'b0);

        random_items = 0;
        while (random_items < 630) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = $urandom_range(1, 6);
            end else if (pick < 95) begin
                len = $urandom_range(7, 40);
            end else begin
                len = $urandom_range(41, 200);
            end
            pick = $urandom_range(0, 9);
            case (pick)
                5, 6:    style = STYLE_QUIET;
                7, 8:    style = STYLE_SWING;
                9:       style = ($urandom_range(0, 1) != 0) ? STYLE_FLOOR : STYLE_CEIL;
                default: style = STYLE_FULL;
            endcase
            add_slice(len, style, $urandom_range(0, 99) < 4);
            random_items += len;
        end
        samples_planned = sample_backlog.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (samples_taken < samples_planned || pending_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            errors++;
            $error("%0d slice results never arrived", pending_results.size());
        end
        $display("Streamed %0d samples in %0d slices (%0d split by the length limit).",
                 samples_taken, slices_closed, limit_closes);
        $display("Checked %0d results; the sender drained the core %0d times.",
                 results_checked, drain_pauses);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
